/* src/circular_deque_with_search_core_defines.svh */
// Assertion macros shared by the deque core modules.
`ifndef CIRCULAR_DEQUE_WITH_SEARCH_CORE_DEFINES_SVH
`define CIRCULAR_DEQUE_WITH_SEARCH_CORE_DEFINES_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low.
`define CDWS_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("deque core check failed");

// Next-cycle implication, sampled on clk, off while rst_n is low.
`define CDWS_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("deque core check failed");

`endif

/* src/cdws_pkg.sv */
// Types and codes shared by the deque core modules.
`timescale 1ns / 1ps
`default_nettype none

package cdws_pkg;

    // Request codes carried in req_type.
    typedef enum logic [2:0] {
        REQ_PUSH_FRONT = 3'd0,
        REQ_PUSH_BACK  = 3'd1,
        REQ_POP_FRONT  = 3'd2,
        REQ_POP_BACK   = 3'd3,
        REQ_READ       = 3'd4,
        REQ_SEARCH     = 3'd5,
        REQ_CLEAR      = 3'd6,
        REQ_STATUS     = 3'd7
    } req_e;

    // Result status codes.
    typedef enum logic [2:0] {
        ST_OK       = 3'd0,
        ST_FULL     = 3'd1,
        ST_EMPTY    = 3'd2,
        ST_RANGE    = 3'd3,
        ST_NOTFOUND = 3'd4
    } status_e;

    // Work handed from the front to the back.
    typedef enum logic [1:0] {
        OP_NONE   = 2'd0,
        OP_WRITE  = 2'd1,
        OP_READ   = 2'd2,
        OP_SEARCH = 2'd3
    } op_e;

    // Back-end sequencer states.
    typedef enum logic [1:0] {
        BK_IDLE   = 2'd0,
        BK_READ   = 2'd1,
        BK_SEARCH = 2'd2
    } bstate_e;

    typedef struct packed {
        logic [2:0]  req_type;
        logic [31:0] value;
        logic [9:0]  index;
    } in_word_t;

    typedef struct packed {
        logic [2:0]  status;
        logic [31:0] data;
        logic [9:0]  position;
        logic [10:0] count;
    } out_word_t;

    // Control part of a queued command.
    typedef struct packed {
        op_e         op;
        status_e     status;
        logic [10:0] count;
    } cmd_ctrl_t;

endpackage

`default_nettype wire

/* src/cdws_fifo.sv */
// Small register FIFO used for the command and result queues.
`timescale 1ns / 1ps
`default_nettype none

module cdws_fifo #(
    parameter int WIDTH   = 8,
    parameter int ENTRIES = 2
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             push,
    output logic                  full,
    input  wire logic [WIDTH-1:0] wdata,
    input  wire logic             pop,
    output logic                  empty,
    output logic [WIDTH-1:0]      rdata
);

    localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int CNT_W = $clog2(ENTRIES + 1);

    logic [WIDTH-1:0] entries_reg [ENTRIES];
    logic [IDX_W-1:0] wr_ptr_reg;
    logic [IDX_W-1:0] rd_ptr_reg;
    logic [CNT_W-1:0] fill_reg;
    logic             do_push;
    logic             do_pop;

    assign full    = (fill_reg == CNT_W'(ENTRIES));
    assign empty   = (fill_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign rdata   = entries_reg[rd_ptr_reg];

    // Store the incoming word
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entries_reg[wr_ptr_reg] <= wdata;
        end
    end

    // Advance pointers and fill level
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == IDX_W'(ENTRIES - 1)) ? '0
                                                                 : wr_ptr_reg + IDX_W'(1);
            end
            if (do_pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == IDX_W'(ENTRIES - 1)) ? '0
                                                                 : rd_ptr_reg + IDX_W'(1);
            end
            if (do_push && !do_pop)
            begin
                fill_reg <= fill_reg + CNT_W'(1);
            end
            else if (do_pop && !do_push)
            begin
                fill_reg <= fill_reg - CNT_W'(1);
            end
        end
    end

endmodule

`default_nettype wire

/* src/cdws_front.sv */
// Request front end: holds head and count, classifies each request.
`timescale 1ns / 1ps
`default_nettype none
`include "circular_deque_with_search_core_defines.svh"

module cdws_front #(
    parameter int DEPTH = 1024,
    parameter int PTR_W = 10,
    parameter int CNT_W = 11
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire cdws_pkg::in_word_t item,
    input  wire logic              push,
    output logic                   full,
    output logic                   cmd_push,
    input  wire logic              cmd_full,
    output cdws_pkg::cmd_ctrl_t    cmd_ctrl,
    output logic [PTR_W-1:0]       cmd_addr,
    output logic [CNT_W-1:0]       cmd_len,
    output logic [31:0]            cmd_value
);

    import cdws_pkg::*;

    localparam int SUM_W = PTR_W + 1;

    logic [PTR_W-1:0] head_reg;
    logic [PTR_W-1:0] head_next;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic [SUM_W-1:0] slot_off;
    logic [SUM_W-1:0] slot_sum;
    logic [PTR_W-1:0] slot;
    logic [PTR_W-1:0] head_dec;
    logic             is_full;
    logic             is_empty;
    logic             in_range;
    req_e             req;
    op_e              op;
    status_e          st;

    assign req       = req_e'(item.req_type);
    assign full      = cmd_full;
    assign cmd_push  = push && !cmd_full;
    assign cmd_value = item.value;
    assign cmd_len   = count_reg;
    assign is_full   = (count_reg == CNT_W'(DEPTH));
    assign is_empty  = (count_reg == '0);
    assign in_range  = (32'(item.index) < 32'(count_reg));
    assign head_dec  = (head_reg == '0) ? PTR_W'(DEPTH - 1) : head_reg - PTR_W'(1);

    // Pick the logical offset that the physical slot is formed from
    always_comb
    begin
        case (req)
            REQ_PUSH_BACK: slot_off = SUM_W'(count_reg);
            REQ_POP_FRONT: slot_off = SUM_W'(1);
            default:       slot_off = SUM_W'(item.index);
        endcase
    end

    // Wrap head plus offset into the ring
    always_comb
    begin
        slot_sum = SUM_W'(head_reg) + slot_off;
        if (slot_sum >= SUM_W'(DEPTH))
        begin
            slot_sum = slot_sum - SUM_W'(DEPTH);
        end
        slot = slot_sum[PTR_W-1:0];
    end

    // Classify the request and form the new head and count
    always_comb
    begin
        head_next  = head_reg;
        count_next = count_reg;
        op         = OP_NONE;
        st         = ST_OK;
        cmd_addr   = slot;
        unique case (req)
            REQ_PUSH_FRONT:
            begin
                if (is_full)
                begin
                    st = ST_FULL;
                end
                else
                begin
                    head_next  = head_dec;
                    count_next = count_reg + CNT_W'(1);
                    op         = OP_WRITE;
                    cmd_addr   = head_dec;
                end
            end
            REQ_PUSH_BACK:
            begin
                if (is_full)
                begin
                    st = ST_FULL;
                end
                else
                begin
                    count_next = count_reg + CNT_W'(1);
                    op         = OP_WRITE;
                end
            end
            REQ_POP_FRONT:
            begin
                if (is_empty)
                begin
                    st = ST_EMPTY;
                end
                else
                begin
                    head_next  = slot;
                    count_next = count_reg - CNT_W'(1);
                end
            end
            REQ_POP_BACK:
            begin
                if (is_empty)
                begin
                    st = ST_EMPTY;
                end
                else
                begin
                    count_next = count_reg - CNT_W'(1);
                end
            end
            REQ_READ:
            begin
                if (in_range)
                begin
                    op = OP_READ;
                end
                else
                begin
                    st = ST_RANGE;
                end
            end
            REQ_SEARCH:
            begin
                op       = OP_SEARCH;
                cmd_addr = head_reg;
            end
            REQ_CLEAR:
            begin
                head_next  = '0;
                count_next = '0;
            end
            REQ_STATUS:
            begin
                head_next = head_reg;
            end
            default:
            begin
                head_next = head_reg;
            end
        endcase
        cmd_ctrl.op     = op;
        cmd_ctrl.status = st;
        cmd_ctrl.count  = 11'(count_next);
    end

    // Commit head and count on each accepted word
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg  <= '0;
            count_reg <= '0;
        end
        else if (cmd_push)
        begin
            head_reg  <= head_next;
            count_reg <= count_next;
        end
    end

    `CDWS_ASSERT_NOW(a_count_bound, 1'b1, count_reg <= CNT_W'(DEPTH))
    `CDWS_ASSERT_NOW(a_write_has_room, cmd_push && (cmd_ctrl.op == OP_WRITE), !is_full)
    `CDWS_ASSERT_NEXT(a_refused_push_holds,
        cmd_push && is_full && (req == REQ_PUSH_FRONT || req == REQ_PUSH_BACK),
        $stable(count_reg) && $stable(head_reg))

endmodule

`default_nettype wire

/* src/cdws_back.sv */
// Command back end: ring memory, reads and the linear search walk.
`timescale 1ns / 1ps
`default_nettype none
`include "circular_deque_with_search_core_defines.svh"

module cdws_back #(
    parameter int DEPTH     = 1024,
    parameter int WORD_BITS = 32,
    parameter int PTR_W     = 10,
    parameter int CNT_W     = 11
) (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                cmd_valid,
    output logic                     cmd_pop,
    input  wire cdws_pkg::cmd_ctrl_t cmd_ctrl,
    input  wire logic [PTR_W-1:0]    cmd_addr,
    input  wire logic [CNT_W-1:0]    cmd_len,
    input  wire logic [31:0]         cmd_value,
    input  wire logic                res_room,
    output logic                     res_push,
    output cdws_pkg::out_word_t      res_word
);

    import cdws_pkg::*;

    logic [WORD_BITS-1:0] store_mem [DEPTH];
    logic [WORD_BITS-1:0] rd_data_reg;
    bstate_e              state_reg;
    bstate_e              state_next;
    logic [31:0]          value_reg;
    logic [CNT_W-1:0]     len_reg;
    logic [CNT_W-1:0]     pos_reg;
    logic [PTR_W-1:0]     addr_reg;
    logic [10:0]          count_reg;
    logic                 start;
    logic                 hit;
    logic                 last;
    logic                 mem_we;
    logic                 mem_re;
    logic [PTR_W-1:0]     rd_addr;
    logic [PTR_W-1:0]     addr_inc;

    assign start    = (state_reg == BK_IDLE) && cmd_valid && res_room;
    assign hit      = (rd_data_reg == WORD_BITS'(value_reg));
    assign last     = ((pos_reg + CNT_W'(1)) == len_reg);
    assign addr_inc = (rd_addr == PTR_W'(DEPTH - 1)) ? '0 : rd_addr + PTR_W'(1);

    // Ring memory: one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            store_mem[cmd_addr] <= WORD_BITS'(cmd_value);
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_re)
        begin
            rd_data_reg <= store_mem[rd_addr];
        end
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            BK_IDLE:
            begin
                if (start && (cmd_ctrl.op == OP_READ))
                begin
                    state_next = BK_READ;
                end
                else if (start && (cmd_ctrl.op == OP_SEARCH) && (cmd_len != '0))
                begin
                    state_next = BK_SEARCH;
                end
            end
            BK_READ:
            begin
                state_next = BK_IDLE;
            end
            BK_SEARCH:
            begin
                if (hit || last)
                begin
                    state_next = BK_IDLE;
                end
            end
            default:
            begin
                state_next = BK_IDLE;
            end
        endcase
    end

    // Outputs: memory strobes, command pop and result word
    always_comb
    begin
        cmd_pop           = 1'b0;
        mem_we            = 1'b0;
        mem_re            = 1'b0;
        rd_addr           = addr_reg;
        res_push          = 1'b0;
        res_word.status   = cmd_ctrl.status;
        res_word.data     = '0;
        res_word.position = '0;
        res_word.count    = cmd_ctrl.count;
        unique case (state_reg)
            BK_IDLE:
            begin
                if (start)
                begin
                    cmd_pop = 1'b1;
                    unique case (cmd_ctrl.op)
                        OP_WRITE:
                        begin
                            mem_we   = 1'b1;
                            res_push = 1'b1;
                        end
                        OP_READ:
                        begin
                            mem_re  = 1'b1;
                            rd_addr = cmd_addr;
                        end
                        OP_SEARCH:
                        begin
                            if (cmd_len == '0)
                            begin
                                res_push        = 1'b1;
                                res_word.status = ST_NOTFOUND;
                            end
                            else
                            begin
                                mem_re  = 1'b1;
                                rd_addr = cmd_addr;
                            end
                        end
                        default:
                        begin
                            res_push = 1'b1;
                        end
                    endcase
                end
            end
            BK_READ:
            begin
                res_push        = 1'b1;
                res_word.status = ST_OK;
                res_word.data   = 32'(rd_data_reg);
                res_word.count  = count_reg;
            end
            BK_SEARCH:
            begin
                res_word.count = count_reg;
                if (hit)
                begin
                    res_push          = 1'b1;
                    res_word.status   = ST_OK;
                    res_word.position = 10'(pos_reg);
                end
                else if (last)
                begin
                    res_push        = 1'b1;
                    res_word.status = ST_NOTFOUND;
                end
                else
                begin
                    mem_re = 1'b1;
                end
            end
            default:
            begin
                res_push = 1'b0;
            end
        endcase
    end

    // Hold command fields and advance the search walk
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            value_reg <= cmd_value;
            len_reg   <= cmd_len;
            count_reg <= cmd_ctrl.count;
            pos_reg   <= '0;
        end
        else if ((state_reg == BK_SEARCH) && mem_re)
        begin
            pos_reg <= pos_reg + CNT_W'(1);
        end
        if (mem_re)
        begin
            addr_reg <= addr_inc;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= BK_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    `CDWS_ASSERT_NOW(a_result_has_room, res_push, res_room || (state_reg != BK_IDLE))
    `CDWS_ASSERT_NOW(a_one_mem_access, mem_we, !mem_re)
    `CDWS_ASSERT_NOW(a_walk_in_bounds, state_reg == BK_SEARCH, pos_reg < len_reg)
    `CDWS_ASSERT_NOW(a_busy_no_pop, state_reg != BK_IDLE, !cmd_pop)

endmodule

`default_nettype wire

/* src/circular_deque_with_search_core.sv */
// Top level of the ring-buffer deque with linear search.
//
//   channel   ports                     handshake
//   request   push, full, item          word taken when push && !full
//   result    empty, pop, result        word taken when pop && !empty
//
// Push, pop, clear, status and a refused read finish in the back end's idle state;
// a read first passes through the registered read port of the ring memory.
// A search makes one memory read per entry walked, up to count entries;
// a match ends it early.
// Two-entry queues sit before and after the back end, so requests keep
// flowing in while a result waits or a search runs, until the command queue fills.
// Reset clears head, count and both queues at once; the ring memory has no
// clearing pass and only entries below the count are ever read.
`timescale 1ns / 1ps
`default_nettype none

module circular_deque_with_search_core #(
    parameter int DEPTH     = 1024,
    parameter int WORD_BITS = 32
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               push,
    output logic                    full,
    input  wire cdws_pkg::in_word_t item,
    output logic                    empty,
    input  wire logic               pop,
    output cdws_pkg::out_word_t     result
);

    import cdws_pkg::*;

    localparam int PTR_W  = $clog2(DEPTH);
    localparam int CNT_W  = $clog2(DEPTH + 1);
    localparam int CTRL_W = $bits(cmd_ctrl_t);
    localparam int CMD_W  = CTRL_W + PTR_W + CNT_W + 32;
    localparam int RES_W  = $bits(out_word_t);

    cmd_ctrl_t        f_ctrl;
    logic [PTR_W-1:0] f_addr;
    logic [CNT_W-1:0] f_len;
    logic [31:0]      f_value;
    logic             f_push;
    logic             cq_full;
    logic             cq_empty;
    logic [CMD_W-1:0] cq_rdata;
    cmd_ctrl_t        b_ctrl;
    logic [PTR_W-1:0] b_addr;
    logic [CNT_W-1:0] b_len;
    logic [31:0]      b_value;
    logic             b_pop;
    logic             rq_full;
    logic             res_push;
    out_word_t        res_word;
    logic [RES_W-1:0] rq_rdata;

    // Classify requests
    cdws_front #(
        .DEPTH (DEPTH),
        .PTR_W (PTR_W),
        .CNT_W (CNT_W)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .item      (item),
        .push      (push),
        .full      (full),
        .cmd_push  (f_push),
        .cmd_full  (cq_full),
        .cmd_ctrl  (f_ctrl),
        .cmd_addr  (f_addr),
        .cmd_len   (f_len),
        .cmd_value (f_value)
    );

    // Queue commands between front and back
    cdws_fifo #(
        .WIDTH   (CMD_W),
        .ENTRIES (2)
    ) u_cmd_q (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (f_push),
        .full  (cq_full),
        .wdata ({f_ctrl, f_addr, f_len, f_value}),
        .pop   (b_pop),
        .empty (cq_empty),
        .rdata (cq_rdata)
    );

    assign {b_ctrl, b_addr, b_len, b_value} = cq_rdata;

    // Carry out commands against the ring memory
    cdws_back #(
        .DEPTH     (DEPTH),
        .WORD_BITS (WORD_BITS),
        .PTR_W     (PTR_W),
        .CNT_W     (CNT_W)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (!cq_empty),
        .cmd_pop   (b_pop),
        .cmd_ctrl  (b_ctrl),
        .cmd_addr  (b_addr),
        .cmd_len   (b_len),
        .cmd_value (b_value),
        .res_room  (!rq_full),
        .res_push  (res_push),
        .res_word  (res_word)
    );

    // Queue finished results for the consumer
    cdws_fifo #(
        .WIDTH   (RES_W),
        .ENTRIES (2)
    ) u_res_q (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (res_push),
        .full  (rq_full),
        .wdata (res_word),
        .pop   (pop),
        .empty (empty),
        .rdata (rq_rdata)
    );

    assign result = out_word_t'(rq_rdata);

endmodule

`default_nettype wire
